### hw/rtl/table_search_engine_defines.svh
// table_search_engine_defines.svh: assertion macros for the table search engine.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TABLE_SEARCH_ENGINE_DEFINES_SVH
`define TABLE_SEARCH_ENGINE_DEFINES_SVH

// checked only while out of reset
`define TSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/tse_pkg.sv
// tse_pkg: types, codes and default sizes of the table search engine.
// Used by table_search_engine and tse_table_mem; depends on nothing.
package tse_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  // fixed field widths of the ports
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned IDX_IN_W   = 10;
  localparam int unsigned VAL_IN_W   = 32;
  localparam int unsigned FIRST_W    = 10;
  localparam int unsigned LAST_W     = 11;
  localparam int unsigned CNT_IN_W   = 11;
  localparam int unsigned POS_W      = 10;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_LINEAR  = 2'd1,
    REQ_ORDERED = 2'd2,
    REQ_BINARY  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIN,
    S_BIN_RD,
    S_BIN_CMP
  } tse_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tse_mem_ctl_t;

endpackage

### hw/rtl/table_search_engine.sv
// table_search_engine: loadable value table with linear, ordered and binary search.
// Depends on tse_pkg, tse_table_mem and table_search_engine_defines.svh.
//
//  channel   handshake                 word
//  --------  ------------------------  -------------------------------------------
//  request   start & !busy              req_type, entry_index, entry_value, range
//  result    done_o (one cycle)        found_o, position_o
//  config    cfg_valid_i & cfg_ready_o cfg_data_i (entry_count)
//
// A write gives no result; busy stays low.
// Linear search: busy while entries are read (one table read per cycle),
// result in the cycle after; an empty table answers in the next cycle.
// Binary search: each probe is a read (S_BIN_RD) then a compare (S_BIN_CMP), up to log2(range)+1 probes.
// Reset clears the FSM, entry_count and the strobe; the table is not cleared.
// The receiver cannot stall: done_o is a one-cycle strobe.
`include "table_search_engine_defines.svh"

module table_search_engine import tse_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic [IDX_IN_W-1:0]        entry_index_i,
  input  logic [VAL_IN_W-1:0]        entry_value_i,
  input  logic [FIRST_W-1:0]         range_first_i,
  input  logic signed [LAST_W-1:0]   range_last_i,
  output logic                       done_o,
  output logic                       found_o,
  output logic [POS_W-1:0]           position_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CNT_IN_W-1:0]        cfg_data_i
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > CNT_IN_W) ? CNT_W : CNT_IN_W;
  localparam int unsigned SW    = CW + 1;

  tse_state_e state_q, state_d;

  logic [CNT_IN_W-1:0]    count_q;
  logic [CW-1:0]          live_cnt;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic                   ordered_q, ordered_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          mid_q, mid_d;
  logic signed [SW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic                   done_q, done_d;
  logic                   found_q, found_d;
  logic [POS_W-1:0]       pos_q, pos_d;

  tse_mem_ctl_t           mem_ctl;
  logic [IDX_W-1:0]       rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;

  logic                   accept;
  req_type_e              req;
  logic                   hit, greater, lin_end, bin_empty;
  logic signed [SW-1:0]   live_m1, last_ext, last_sat;
  logic [CW:0]            mid_sum;
  logic [CW-1:0]          idx_inc;

  assign accept      = start && !busy;
  assign req         = req_type_e'(req_type_i);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // oversized count acts as the table depth
  assign live_cnt = (CW'(count_q) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);

  assign hit       = (rd_data == key_q);
  assign greater   = (rd_data > key_q);
  assign idx_inc   = idx_q + CW'(1);
  assign lin_end   = (idx_inc == live_cnt);
  assign bin_empty = (lo_q > hi_q);

  assign live_m1  = signed'(SW'(live_cnt)) - SW'(1);
  assign last_ext = SW'(range_last_i);
  assign last_sat = (last_ext > live_m1) ? live_m1 : last_ext;
  // lo and hi are non-negative whenever the midpoint is used
  assign mid_sum  = {1'b0, lo_q[CW-1:0]} + {1'b0, hi_q[CW-1:0]};

  tse_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (IDX_W'(entry_index_i)),
    .wr_data_i (VALUE_WIDTH'(entry_value_i)),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req)
            REQ_WRITE:   state_d = S_IDLE;
            REQ_LINEAR,
            REQ_ORDERED: state_d = (live_cnt == '0) ? S_IDLE : S_LIN;
            REQ_BINARY:  state_d = S_BIN_RD;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_LIN: begin
        if (hit || (ordered_q && greater) || lin_end) begin
          state_d = S_IDLE;
        end
      end
      S_BIN_RD:  state_d = bin_empty ? S_IDLE : S_BIN_CMP;
      S_BIN_CMP: state_d = hit ? S_IDLE : S_BIN_RD;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath, memory control and result
  always_comb begin
    key_d         = key_q;
    ordered_d     = ordered_q;
    idx_d         = idx_q;
    mid_d         = mid_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    done_d        = 1'b0;
    found_d       = 1'b0;
    pos_d         = '0;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    rd_addr       = idx_q[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d     = VALUE_WIDTH'(entry_value_i);
          ordered_d = (req == REQ_ORDERED);
          unique case (req)
            REQ_WRITE: begin
              mem_ctl.wr_en = ({{(32-IDX_IN_W){1'b0}}, entry_index_i} < 32'(TABLE_DEPTH));
            end
            REQ_LINEAR,
            REQ_ORDERED: begin
              if (live_cnt == '0) begin
                done_d = 1'b1;
              end else begin
                idx_d         = '0;
                mem_ctl.rd_en = 1'b1;
                rd_addr       = '0;
              end
            end
            REQ_BINARY: begin
              lo_d = SW'(range_first_i);
              hi_d = last_sat;
            end
            default: ;
          endcase
        end
      end
      S_LIN: begin
        if (hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = idx_q[POS_W-1:0];
        end else if ((ordered_q && greater) || lin_end) begin
          done_d = 1'b1;
        end else begin
          idx_d         = idx_inc;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_inc[IDX_W-1:0];
        end
      end
      S_BIN_RD: begin
        if (bin_empty) begin
          done_d = 1'b1;
        end else begin
          mid_d         = mid_sum[CW:1];
          mem_ctl.rd_en = 1'b1;
          rd_addr       = mid_sum[IDX_W:1];
        end
      end
      S_BIN_CMP: begin
        if (hit) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = mid_q[POS_W-1:0];
        end else if (greater) begin
          hi_d = signed'(SW'(mid_q)) - SW'(1);
        end else begin
          lo_d = signed'(SW'(mid_q)) + SW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    ordered_q <= ordered_d;
    idx_q     <= idx_d;
    mid_q     <= mid_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
  end

  assign done_o     = done_q;
  assign found_o    = found_q;
  assign position_o = pos_q;

  `TSE_ASSERT(a_done_not_busy, !(done_o && busy), "result strobe while busy")
  `TSE_ASSERT(a_done_after_work, done_o |-> ($past(busy) || $past(accept)), "result from nowhere")
  `TSE_ASSERT(a_miss_pos_zero, (done_o && !found_o) |-> (position_o == '0), "miss with position")
  `TSE_ASSERT(a_lin_in_range, (state_q == S_LIN) |-> (idx_q < live_cnt), "linear index past count")
  `TSE_ASSERT(a_bin_hi_sat, (state_q == S_BIN_RD && !bin_empty) |-> (hi_q <= live_m1 && lo_q >= 0),
    "binary range outside table")

endmodule

### hw/rtl/tse_table_mem.sv
// tse_table_mem: single-port-write, single-port-read table RAM, registered read.
// Depends on tse_pkg for the port control struct and the default sizes.
module tse_table_mem import tse_pkg::*; #(
  parameter int unsigned DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned WIDTH = DEF_VALUE_WIDTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  tse_mem_ctl_t     ctl_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
